@@ design/gat_pkg.sv @@
package gat_pkg;

    localparam int ANGLE_BITS_DEF = 20;
    localparam int RATE_W         = 18;
    localparam int PERIOD_W       = 16;
    localparam int PERCENT_W      = 7;
    localparam int PROD_W         = RATE_W + 1 + PERIOD_W + 1;
    localparam int STEP_W         = PROD_W - PERIOD_W;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PERCENT_FULL   = 100;
    localparam int PCT_MUL_W      = 7;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(6554);

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RATE_OFFSET   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REST_ANGLE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRESSED_ANGLE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic KIND_RATE   = 1'b0;
    localparam logic KIND_PRESET = 1'b1;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_UPDATE,
        BS_PREP,
        BS_DIVIDE,
        BS_DONE
    } t_bstate;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ design/gat_in_if.sv @@
interface gat_in_if
    import gat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [RATE_W-1:0]     rate;
    logic signed [ANGLE_BITS-1:0] preset_angle;

    modport source (output valid, kind, rate, preset_angle, input ready);
    modport sink   (input valid, kind, rate, preset_angle, output ready);
endinterface

@@ design/gat_out_if.sv @@
interface gat_out_if
    import gat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle;
    logic [PERCENT_W-1:0]         percent;
    logic                         limited;

    modport source (output valid, angle, percent, limited, input ready);
    modport sink   (input valid, angle, percent, limited, output ready);
endinterface

@@ design/gat_front.sv @@
module gat_front
    import gat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int CMD_W      = 1 + max_int(ANGLE_BITS, STEP_W)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gat_in_if.sink                   i_in,
    input  logic signed [RATE_W-1:0] i_rate_offset,
    input  logic [PERIOD_W-1:0]      i_sample_period,
    output logic                     o_push_valid,
    input  logic                     i_push_ready,
    output logic [CMD_W-1:0]         o_push_data
);
    localparam int VAL_W = CMD_W - 1;

    logic                         r_valid;
    logic                         r_kind;
    logic signed [ANGLE_BITS-1:0] r_preset;
    logic signed [PROD_W-1:0]     r_prod;

    logic                         accept;
    logic signed [RATE_W:0]       diff;
    logic signed [PERIOD_W:0]     period_s;
    logic signed [STEP_W-1:0]     step;
    logic signed [VAL_W-1:0]      value;

    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;

    assign diff     = (RATE_W+1)'(i_in.rate) - (RATE_W+1)'(i_rate_offset);
    assign period_s = signed'({1'b0, i_sample_period});

    // floor scaling: arithmetic shift of the Q24 product
    assign step  = r_prod[PROD_W-1:PERIOD_W];
    assign value = (r_kind == KIND_PRESET) ? VAL_W'(r_preset) : VAL_W'(step);

    assign o_push_valid = r_valid;
    assign o_push_data  = {r_kind, value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_in.kind;
            r_preset <= i_in.preset_angle;
            r_prod   <= PROD_W'(diff * period_s);
        end
    end
endmodule

@@ design/gat_queue.sv @@
module gat_queue
    import gat_pkg::*;
#(
    parameter int W = 1 + max_int(ANGLE_BITS_DEF, STEP_W)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end
endmodule

@@ design/gat_back.sv @@
module gat_back
    import gat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int CMD_W      = 1 + max_int(ANGLE_BITS, STEP_W)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  logic [CMD_W-1:0]             i_q_data,
    input  logic signed [ANGLE_BITS-1:0] i_rest_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pressed_angle,
    gat_out_if.source                    o_out
);
    localparam int AW    = ANGLE_BITS;
    localparam int VAL_W = CMD_W - 1;
    localparam int SUM_W = VAL_W + 1;
    localparam int NUM_W = AW + 1 + PCT_MUL_W;
    localparam int CNT_W = $clog2(PERCENT_W);

    t_bstate r_state;
    t_bstate n_state;

    logic                  r_kind;
    logic signed [VAL_W-1:0] r_val;
    logic signed [AW-1:0]  r_angle;
    logic                  r_lim;
    logic [NUM_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_dsh;
    logic                  r_zero;
    logic [PERCENT_W-1:0]  r_q;
    logic [CNT_W-1:0]      r_cnt;

    logic                  r_out_valid;
    logic signed [AW-1:0]  r_out_angle;
    logic [PERCENT_W-1:0]  r_out_pct;
    logic                  r_out_lim;

    logic                  pop;
    logic                  load_out;

    logic                  rev;
    logic signed [AW-1:0]  lo;
    logic signed [AW-1:0]  hi;
    logic signed [SUM_W-1:0] sum;
    logic signed [AW-1:0]  a_cl;
    logic signed [AW:0]    num;
    logic signed [AW:0]    den;
    logic                  ge;

    assign rev = (i_rest_angle > i_pressed_angle);
    assign lo  = rev ? i_pressed_angle : i_rest_angle;
    assign hi  = rev ? i_rest_angle : i_pressed_angle;
    assign sum = SUM_W'(r_angle) + SUM_W'(r_val);

    always_comb begin
        if (r_angle < lo) begin
            a_cl = lo;
        end else if (r_angle > hi) begin
            a_cl = hi;
        end else begin
            a_cl = r_angle;
        end
    end

    assign num = rev ? ((AW+1)'(i_rest_angle) - (AW+1)'(a_cl))
                     : ((AW+1)'(a_cl) - (AW+1)'(i_rest_angle));
    assign den = rev ? ((AW+1)'(i_rest_angle) - (AW+1)'(i_pressed_angle))
                     : ((AW+1)'(i_pressed_angle) - (AW+1)'(i_rest_angle));
    assign ge  = (r_rem >= r_dsh);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = BS_UPDATE;
                end
            end
            BS_UPDATE: n_state = BS_PREP;
            BS_PREP:   n_state = BS_DIVIDE;
            BS_DIVIDE: begin
                if (r_cnt == '0) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BS_IDLE:   pop = i_q_valid;
            BS_DONE:   load_out = !r_out_valid || o_out.ready;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign o_q_ready = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_angle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_UPDATE) begin
                if (r_kind == KIND_PRESET) begin
                    r_angle <= AW'(r_val);
                end else if (sum < SUM_W'(lo)) begin
                    r_angle <= lo;
                end else if (sum > SUM_W'(hi)) begin
                    r_angle <= hi;
                end else begin
                    r_angle <= AW'(sum);
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind <= i_q_data[CMD_W-1];
            r_val  <= signed'(i_q_data[VAL_W-1:0]);
        end
        if (r_state == BS_UPDATE) begin
            r_lim <= (r_kind == KIND_RATE) &&
                     ((sum < SUM_W'(lo)) || (sum > SUM_W'(hi)));
        end
        if (r_state == BS_PREP) begin
            r_rem  <= NUM_W'($unsigned(num)) * NUM_W'(PERCENT_FULL);
            r_dsh  <= NUM_W'($unsigned(den)) << (PERCENT_W - 1);
            r_zero <= (den == '0);
            r_q    <= '0;
            r_cnt  <= CNT_W'(PERCENT_W - 1);
        end
        if (r_state == BS_DIVIDE) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[PERCENT_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (load_out) begin
            r_out_angle <= r_angle;
            r_out_pct   <= r_zero ? '0 : r_q;
            r_out_lim   <= r_lim;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.angle   = r_out_angle;
    assign o_out.percent = r_out_pct;
    assign o_out.limited = r_out_lim;
endmodule

@@ design/gyro_angle_tracker_percent.sv @@
// channel   dir  words                          handshake
// i_in      in   kind, rate, preset_angle       valid/ready
// o_out     out  angle, percent, limited        valid/ready
// i_cfg_*   in   register index, data           write enable, no stall
//
// Front takes a word per cycle while its stage can drain into a 2-deep queue.
// Back works on one word at a time: load, update, prep, 7 divider steps, handoff;
// the divider steps run the shift-subtract percentage divider.
// Synchronous active-low reset clears the angle, queue, FSM and config, but sets the sample period to 6554.
// Output register lets the back start the next word while a result waits.
module gyro_angle_tracker_percent
    import gat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int CFG_W      = max_int(ANGLE_BITS, RATE_W)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gat_in_if.sink               i_in,
    gat_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CMD_W = 1 + max_int(ANGLE_BITS, STEP_W);

    logic signed [RATE_W-1:0]     r_rate_offset;
    logic signed [ANGLE_BITS-1:0] r_rest_angle;
    logic signed [ANGLE_BITS-1:0] r_pressed_angle;
    logic [PERIOD_W-1:0]          r_sample_period;

    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [CMD_W-1:0] pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_offset   <= '0;
            r_rest_angle    <= '0;
            r_pressed_angle <= '0;
            r_sample_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RATE_OFFSET:   r_rate_offset   <= signed'(i_cfg_data[RATE_W-1:0]);
                REG_REST_ANGLE:    r_rest_angle    <= signed'(i_cfg_data[ANGLE_BITS-1:0]);
                REG_PRESSED_ANGLE: r_pressed_angle <= signed'(i_cfg_data[ANGLE_BITS-1:0]);
                REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    gat_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_rate_offset   (r_rate_offset),
        .i_sample_period (r_sample_period),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_push_data     (push_data)
    );

    gat_queue #(
        .W (CMD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    gat_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (pop_valid),
        .o_q_ready       (pop_ready),
        .i_q_data        (pop_data),
        .i_rest_angle    (r_rest_angle),
        .i_pressed_angle (r_pressed_angle),
        .o_out           (o_out)
    );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import gat_pkg::*;

    localparam int ANGLE_W    = ANGLE_BITS_DEF;
    localparam int CFG_W      = (ANGLE_BITS_DEF > RATE_W) ? ANGLE_BITS_DEF : RATE_W;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 500;
    localparam int N_PHASES   = 12;
    localparam int PHASE_WORDS = 135;

    typedef struct {
        logic                      kind;
        logic signed [RATE_W-1:0]  rate;
        logic signed [ANGLE_W-1:0] preset;
    } t_gyro_word;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic [PERCENT_W-1:0]      percent;
        logic                      limited;
    } t_track_result;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;

    gat_in_if  in_if ();
    gat_out_if out_if ();

    gyro_angle_tracker_percent uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    longint cfg_rate_ofs = 0;
    longint cfg_rest     = 0;
    longint cfg_pressed  = 0;
    longint cfg_period   = 6554;
    longint trk_angle    = 0;

    t_gyro_word    pending_words[$];
    t_track_result expected_results[$];

    int  n_queued   = 0;
    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_presets  = 0;
    int  n_clamped  = 0;
    int  n_errors   = 0;
    int  idle_cycles = 0;
    logic in_took   = 1'b0;
    bit  tx_idle    = 1'b1;
    bit  rx_idle    = 1'b1;
    bit  hold_req   = 1'b0;
    int  hold_left  = 0;
    int  tx_gap     = 0;
    int  rx_gap     = 0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint rnd_s(int w);
        longint v;
        v = longint'($urandom) & ((64'sd1 << w) - 1);
        if (v >= (64'sd1 << (w - 1)))
            v -= (64'sd1 << w);
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PERCENT_W-1:0] travel_pct(longint a);
        longint lo, hi, num, den;
        logic   rev;
        rev = cfg_rest > cfg_pressed;
        lo  = rev ? cfg_pressed : cfg_rest;
        hi  = rev ? cfg_rest : cfg_pressed;
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        if (rev) begin
            num = cfg_rest - a;
            den = cfg_rest - cfg_pressed;
        end else begin
            num = a - cfg_rest;
            den = cfg_pressed - cfg_rest;
        end
        if (den <= 0 || num <= 0)
            return '0;
        num = (num * PERCENT_FULL) / den;
        if (num > PERCENT_FULL)
            num = PERCENT_FULL;
        return num[PERCENT_W-1:0];
    endfunction

    function automatic t_track_result track_word(t_gyro_word w);
        t_track_result r;
        longint diff, sum, lo, hi;
        r.limited = 1'b0;
        if (w.kind == KIND_PRESET) begin
            trk_angle = w.preset;
        end else begin
            diff = longint'(w.rate) - cfg_rate_ofs;
            // arithmetic shift floors the Q24 product down to Q8
            sum = trk_angle + ((diff * cfg_period) >>> PERIOD_W);
            lo  = (cfg_rest > cfg_pressed) ? cfg_pressed : cfg_rest;
            hi  = (cfg_rest > cfg_pressed) ? cfg_rest : cfg_pressed;
            if (sum < lo) begin
                sum = lo;
                r.limited = 1'b1;
            end
            if (sum > hi) begin
                sum = hi;
                r.limited = 1'b1;
            end
            trk_angle = sum;
        end
        r.angle   = trk_angle[ANGLE_W-1:0];
        r.percent = travel_pct(trk_angle);
        return r;
    endfunction

    function automatic void add_rate(longint r);
        t_gyro_word w;
        w.kind   = KIND_RATE;
        w.rate   = r[RATE_W-1:0];
        w.preset = rnd_s(ANGLE_W);
        pending_words.push_back(w);
        n_queued++;
    endfunction

    function automatic void add_preset(longint a);
        t_gyro_word w;
        w.kind   = KIND_PRESET;
        w.rate   = rnd_s(RATE_W);
        w.preset = a[ANGLE_W-1:0];
        pending_words.push_back(w);
        n_queued++;
    endfunction

    task automatic set_reg(logic [REG_IDX_W-1:0] idx, longint val);
        logic signed [RATE_W-1:0]  v18;
        logic signed [ANGLE_W-1:0] v20;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_W-1:0];
        v18 = val[RATE_W-1:0];
        v20 = val[ANGLE_W-1:0];
        case (idx)
            REG_RATE_OFFSET:   cfg_rate_ofs = v18;
            REG_REST_ANGLE:    cfg_rest = v20;
            REG_PRESSED_ANGLE: cfg_pressed = v20;
            REG_SAMPLE_PERIOD: cfg_period = val & 64'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(longint ofs, longint rest, longint pressed, longint per);
        set_reg(REG_RATE_OFFSET, ofs);
        set_reg(REG_REST_ANGLE, rest);
        set_reg(REG_PRESSED_ANGLE, pressed);
        set_reg(REG_SAMPLE_PERIOD, per);
    endtask

    task automatic settle();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // input side
    always @(negedge clk) begin : drive_in
        t_gyro_word w;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                in_if.valid        <= 1'b1;
                in_if.kind         <= w.kind;
                in_if.rate         <= w.rate;
                in_if.preset_angle <= w.preset;
                if (tx_idle)
                    tx_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : watch_in
        t_gyro_word    w;
        t_track_result r;
        in_took <= rst_n && in_if.valid && in_if.ready;
        if (rst_n && in_if.valid && in_if.ready) begin
            w.kind   = in_if.kind;
            w.rate   = in_if.rate;
            w.preset = in_if.preset_angle;
            r = track_word(w);
            expected_results.push_back(r);
            n_accepted++;
            if (w.kind == KIND_PRESET)
                n_presets++;
            if (r.limited)
                n_clamped++;
        end
    end

    // output side
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (rx_idle && $urandom_range(0, 2) == 0)
                rx_gap = pick_gap();
        end
    end

    always @(posedge clk) begin : watch_out
        t_track_result e;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: angle %0d", out_if.angle);
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (out_if.angle !== e.angle) begin
                    $error("angle: expected %0d, got %0d", e.angle, out_if.angle);
                    n_errors++;
                end
                if (out_if.percent !== e.percent) begin
                    $error("percent: expected %0d, got %0d", e.percent, out_if.percent);
                    n_errors++;
                end
                if (out_if.limited !== e.limited) begin
                    $error("limited: expected %0d, got %0d", e.limited, out_if.limited);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_if.valid        = 1'b0;
        in_if.kind         = 1'b0;
        in_if.rate         = '0;
        in_if.preset_angle = '0;
        out_if.ready       = 1'b0;
    end

    initial begin : stimulus
        longint ofs, rest, pressed, per, lo, hi, span;
        int     sel;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero span, presets outside it
        add_rate(131071);
        add_rate(-131072);
        add_rate(0);
        add_preset(524287);
        add_preset(-524288);
        add_rate(0);
        settle();

        set_all(0, -25600, 25600, 65535);
        add_preset(0);
        add_rate(131071);
        add_rate(-131072);
        add_preset(-524288);
        add_preset(524287);
        add_preset(12800);
        add_rate(100);
        settle();

        // reversed full span, zero period
        set_all(-131072, 524287, -524288, 0);
        add_rate(131071);
        add_preset(-524288);
        add_preset(524287);
        add_rate(-131072);
        settle();

        // period 1: negative steps floor away from zero
        set_all(131071, 524287, -524288, 1);
        add_rate(-131072);
        add_rate(131071);
        add_preset(0);
        add_rate(-1);
        settle();

        for (int k = 0; k < N_PHASES; k++) begin
            case (k % 4)
                0: begin
                    rest    = rnd_s(ANGLE_W);
                    pressed = rnd_s(ANGLE_W);
                end
                1: begin
                    rest    = rnd_s(16);
                    pressed = rest + $urandom_range(1, 30000);
                end
                2: begin
                    rest    = rnd_s(16);
                    pressed = rest - $urandom_range(1, 30000);
                end
                default: begin
                    rest    = rnd_s(ANGLE_W);
                    pressed = rest;
                end
            endcase
            if (k == 7) begin
                rest    = -524288;
                pressed = 524287;
            end else if (k == 11) begin
                rest    = 524287;
                pressed = -524288;
            end
            ofs = ($urandom_range(0, 1) == 0) ? rnd_s(10) : rnd_s(RATE_W);
            per = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 65535)
                                              : $urandom_range(1, 8000);
            if (k == 4) begin
                ofs = -131072;
                per = 65535;
            end else if (k == 8) begin
                ofs = 131071;
                per = 1;
            end else if (k == 5) begin
                per = 0;
            end
            set_all(ofs, rest, pressed, per);

            tx_idle = !(k == 2 || k == 9);
            rx_idle = !(k == 2 || k == 9 || k == 10);

            lo   = (cfg_rest > cfg_pressed) ? cfg_pressed : cfg_rest;
            hi   = (cfg_rest > cfg_pressed) ? cfg_rest : cfg_pressed;
            span = hi - lo + 1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    add_preset(lo + longint'($urandom) % span);
                else if (sel < 15)
                    add_preset(rnd_s(ANGLE_W));
                else if (sel < 50)
                    add_rate(rnd_s(RATE_W));
                else if (sel < 95)
                    add_rate(cfg_rate_ofs + rnd_s(13));
                else
                    add_rate(($urandom_range(0, 1) == 0) ? 131071 : -131072);
            end
            // sink stalls long enough for the block to back up into the sender
            if (k == 6)
                hold_req = 1'b1;
            settle();
        end

        $display("tb: %0d words (%0d presets), %0d results checked, %0d clamped",
                 n_accepted, n_presets, n_checked, n_clamped);
        $display("tb: %0d settings incl. zero span, reversed, zero and full period",
                 N_PHASES + 4);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/gat_pkg.sv
design/gat_in_if.sv
design/gat_out_if.sv
design/gat_front.sv
design/gat_queue.sv
design/gat_back.sv
design/gyro_angle_tracker_percent.sv
tb/tb.sv
